FILE: hdl/orc_pkg.sv
// orc_pkg: shared types, constants and arithmetic helpers for the orthogonal
// connector router. No dependencies.
package orc_pkg;

  localparam int CoordW = 16;   // Q11.4 coordinate width
  localparam int LenW   = 12;   // stub length register width
  localparam int ExtW   = ((CoordW > LenW) ? CoordW : LenW) + 2;
  localparam int NumPts = 4;
  localparam int IdxW   = $clog2(NumPts);

  localparam logic [LenW-1:0] StubLenRst = LenW'(160);  // 10.0

  localparam logic signed [ExtW-1:0] ExtMax = ExtW'((64'sd1 <<< (CoordW - 1)) - 64'sd1);
  localparam logic signed [ExtW-1:0] ExtMin = ExtW'(-(64'sd1 <<< (CoordW - 1)));

  typedef enum logic [1:0] {
    DirRight = 2'd0,
    DirUp    = 2'd1,
    DirLeft  = 2'd2,
    DirDown  = 2'd3
  } dir_e;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    dir_e   start_dir;
    coord_t start_x;
    coord_t start_y;
    dir_e   end_dir;
    coord_t end_x;
    coord_t end_y;
  } req_t;

  typedef struct packed {
    logic [NumPts-1:0][CoordW-1:0] x;
    logic [NumPts-1:0][CoordW-1:0] y;
    logic [IdxW-1:0]               last_idx;
  } route_t;

  // v + len (neg = 0) or v - len (neg = 1), saturated to the coordinate range
  function automatic coord_t sat_off(input coord_t v, input logic [LenW-1:0] len,
                                     input logic neg);
    logic signed [ExtW-1:0] ve;
    logic signed [ExtW-1:0] le;
    logic signed [ExtW-1:0] s;
    ve = ExtW'(v);
    le = $signed({{(ExtW - LenW){1'b0}}, len});
    s  = neg ? (ve - le) : (ve + le);
    if (s > ExtMax) begin
      return coord_t'(ExtMax[CoordW-1:0]);
    end else if (s < ExtMin) begin
      return coord_t'(ExtMin[CoordW-1:0]);
    end
    return coord_t'(s[CoordW-1:0]);
  endfunction

  // floor((a + b) / 2) at full precision
  function automatic coord_t mid_floor(input coord_t a, input coord_t b);
    logic signed [CoordW:0] s;
    s = $signed({a[CoordW-1], a}) + $signed({b[CoordW-1], b});
    return coord_t'(s[CoordW:1]);
  endfunction

endpackage

FILE: hdl/orc_route_calc.sv
// orc_route_calc: combinational waypoint generation for one request.
// Depends on orc_pkg.
module orc_route_calc (
  input  orc_pkg::req_t              req_i,
  input  logic [orc_pkg::LenW-1:0]   stub_len_i,
  output orc_pkg::route_t            route_o
);
  import orc_pkg::*;

  coord_t fx, fy, tx, ty;
  coord_t sx, sy, ex, ey;
  coord_t m_far, m_mx, m_my;
  logic   horiz_s, fwd, away, ahead, side;

  assign fx = req_i.start_x;
  assign fy = req_i.start_y;
  assign tx = req_i.end_x;
  assign ty = req_i.end_y;

  // stub points
  always_comb begin
    sx = fx;
    sy = fy;
    ex = tx;
    ey = ty;
    case (req_i.start_dir)
      DirRight: sx = sat_off(fx, stub_len_i, 1'b0);
      DirUp:    sy = sat_off(fy, stub_len_i, 1'b1);
      DirLeft:  sx = sat_off(fx, stub_len_i, 1'b1);
      default:  sy = sat_off(fy, stub_len_i, 1'b0);
    endcase
    case (req_i.end_dir)
      DirRight: ex = sat_off(tx, stub_len_i, 1'b0);
      DirUp:    ey = sat_off(ty, stub_len_i, 1'b1);
      DirLeft:  ex = sat_off(tx, stub_len_i, 1'b1);
      default:  ey = sat_off(ty, stub_len_i, 1'b0);
    endcase
  end

  assign horiz_s = (req_i.start_dir == DirRight) || (req_i.start_dir == DirLeft);
  // "forward" start: right in x, down in y (growing coordinate)
  assign fwd = (req_i.start_dir == DirRight) || (req_i.start_dir == DirDown);

  assign m_mx = mid_floor(fx, tx);
  assign m_my = mid_floor(fy, ty);

  // outer line for same-direction pairs
  always_comb begin
    if (horiz_s) begin
      m_far = fwd ? sat_off(((fx > tx) ? fx : tx), stub_len_i, 1'b0)
                  : sat_off(((fx < tx) ? fx : tx), stub_len_i, 1'b1);
    end else begin
      m_far = fwd ? sat_off(((fy > ty) ? fy : ty), stub_len_i, 1'b0)
                  : sat_off(((fy < ty) ? fy : ty), stub_len_i, 1'b1);
    end
  end

  // facing-away test for opposing pairs, ahead tests for perpendicular pairs
  always_comb begin
    if (horiz_s) begin
      away  = fwd ? (fx > tx) : (fx < tx);
      ahead = fwd ? (fx < tx) : (fx > tx);
      side  = (req_i.end_dir == DirUp) ? (fy < ty) : (fy > ty);
    end else begin
      away  = fwd ? (fy > ty) : (fy < ty);
      ahead = fwd ? (fy < ty) : (fy > ty);
      side  = (req_i.end_dir == DirRight) ? (fx > tx) : (fx < tx);
    end
  end

  always_comb begin
    route_o = '0;
    if (horiz_s) begin
      if (req_i.end_dir == req_i.start_dir) begin
        route_o.x[0] = m_far; route_o.y[0] = fy;
        route_o.x[1] = m_far; route_o.y[1] = ty;
        route_o.last_idx = IdxW'(1);
      end else if (!req_i.end_dir[0]) begin
        if (away) begin
          route_o.x[0] = sx;   route_o.y[0] = sy;
          route_o.x[1] = sx;   route_o.y[1] = m_my;
          route_o.x[2] = ex;   route_o.y[2] = m_my;
          route_o.x[3] = ex;   route_o.y[3] = ey;
          route_o.last_idx = IdxW'(3);
        end else begin
          route_o.x[0] = m_mx; route_o.y[0] = fy;
          route_o.x[1] = m_mx; route_o.y[1] = ty;
          route_o.last_idx = IdxW'(1);
        end
      end else if (ahead && side) begin
        route_o.x[0] = tx; route_o.y[0] = fy;
        route_o.last_idx = IdxW'(0);
      end else begin
        route_o.x[0] = sx; route_o.y[0] = sy;
        route_o.x[1] = sx; route_o.y[1] = ey;
        route_o.x[2] = ex; route_o.y[2] = ey;
        route_o.last_idx = IdxW'(2);
      end
    end else begin
      if (req_i.end_dir == req_i.start_dir) begin
        route_o.x[0] = fx; route_o.y[0] = m_far;
        route_o.x[1] = tx; route_o.y[1] = m_far;
        route_o.last_idx = IdxW'(1);
      end else if (req_i.end_dir[0]) begin
        if (away) begin
          route_o.x[0] = sx;   route_o.y[0] = sy;
          route_o.x[1] = m_mx; route_o.y[1] = sy;
          route_o.x[2] = m_mx; route_o.y[2] = ey;
          route_o.x[3] = ex;   route_o.y[3] = ey;
          route_o.last_idx = IdxW'(3);
        end else begin
          route_o.x[0] = fx; route_o.y[0] = m_my;
          route_o.x[1] = tx; route_o.y[1] = m_my;
          route_o.last_idx = IdxW'(1);
        end
      end else if (ahead && side) begin
        route_o.x[0] = fx; route_o.y[0] = ty;
        route_o.last_idx = IdxW'(0);
      end else begin
        route_o.x[0] = sx; route_o.y[0] = sy;
        route_o.x[1] = ex; route_o.y[1] = sy;
        route_o.x[2] = ex; route_o.y[2] = ey;
        route_o.last_idx = IdxW'(2);
      end
    end
  end

endmodule

FILE: hdl/orc_serialiser.sv
// orc_serialiser: holds one computed route and issues its waypoints one beat
// per cycle. Depends on orc_pkg.
module orc_serialiser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  orc_pkg::route_t            route_i,
  output logic                       free_o,
  output logic                       valid_o,
  output logic [orc_pkg::CoordW-1:0] x_o,
  output logic [orc_pkg::CoordW-1:0] y_o,
  output logic                       last_o
);
  import orc_pkg::*;

  route_t          route_q;
  logic            valid_q, valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            at_last;

  assign at_last = (idx_q == route_q.last_idx);
  assign free_o  = !valid_q || at_last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (valid_q) begin
      valid_d = !at_last;
      idx_d   = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      route_q <= route_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = route_q.x[idx_q];
  assign y_o     = route_q.y[idx_q];
  assign last_o  = valid_q && at_last;

endmodule

FILE: hdl/orthogonal_connector_router_unit.sv
// orthogonal_connector_router_unit: top level of the orthogonal connector router.
// Depends on orc_pkg, orc_route_calc and orc_serialiser.
// Path: the first waypoint passes the request register and then the route register
//   before it reaches the result ports; it waits longer while an earlier route drains.
// Throughput: one waypoint beat per cycle; a request holds the single result port for
//   its 1 to 4 waypoints while they drain from the route register.
// Reset (rst_ni low, async): request and route registers emptied, stub length 10.0.
// The receiver cannot stall: every strobed beat is taken in its cycle.
module orthogonal_connector_router_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         start_dir_i,
  input  logic signed [orc_pkg::CoordW-1:0]  start_x_i,
  input  logic signed [orc_pkg::CoordW-1:0]  start_y_i,
  input  logic [1:0]                         end_dir_i,
  input  logic signed [orc_pkg::CoordW-1:0]  end_x_i,
  input  logic signed [orc_pkg::CoordW-1:0]  end_y_i,
  // waypoint beats
  output logic                               result_valid_o,
  output logic signed [orc_pkg::CoordW-1:0]  corner_x_o,
  output logic signed [orc_pkg::CoordW-1:0]  corner_y_o,
  output logic                               last_corner_o,
  // stub length register
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [orc_pkg::LenW-1:0]           cfg_data_i
);
  import orc_pkg::*;

  logic            accept;
  logic            req_valid_q, req_valid_d;
  req_t            req_q;
  logic [LenW-1:0] stub_len_q;
  logic            route_free;
  logic            route_load;
  route_t          route;
  logic [CoordW-1:0] ser_x, ser_y;

  // Register writes are to be made only while idle; the block does not enforce this, and has no guard.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stub_len_q <= StubLenRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      stub_len_q <= cfg_data_i;
    end
  end

  // Request register: refilled in the same cycle it hands its beat on, so a
  // new request is taken every cycle the route register can absorb one.
  assign route_load = req_valid_q && route_free;
  assign busy       = req_valid_q && !route_free;
  assign accept     = start && !busy;

  assign req_valid_d = accept || (req_valid_q && !route_load);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.start_dir <= dir_e'(start_dir_i);
      req_q.start_x   <= start_x_i;
      req_q.start_y   <= start_y_i;
      req_q.end_dir   <= dir_e'(end_dir_i);
      req_q.end_x     <= end_x_i;
      req_q.end_y     <= end_y_i;
    end
  end

  // Route computation: stubs, midpoint and corner selection in one pass.
  orc_route_calc u_calc (
    .req_i      (req_q),
    .stub_len_i (stub_len_q),
    .route_o    (route)
  );

  // Route register and waypoint sequencing.
  orc_serialiser u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (route_load),
    .route_i (route),
    .free_o  (route_free),
    .valid_o (result_valid_o),
    .x_o     (ser_x),
    .y_o     (ser_y),
    .last_o  (last_corner_o)
  );

  assign corner_x_o = $signed(ser_x);
  assign corner_y_o = $signed(ser_y);

  // A loaded route shows its first beat in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    route_load |=> result_valid_o)
    else $error("route loaded but no beat issued");

  // Beats of one route come without gaps until the last one.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_corner_o) |=> result_valid_o)
    else $error("gap inside a route");

  // An accepted request is held until handed to the route register.
  a_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> req_valid_q)
    else $error("accepted request lost");

  // Busy is only raised while a route is draining and not yet at its final beat.
  a_busy_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (result_valid_o && !last_corner_o))
    else $error("busy without a route draining");

endmodule
